FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("assertion failed");
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_NEVER(label, clk, rst_n, expr)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/tvs_pkg.sv
`timescale 1ns / 1ps
package tvs_pkg;
  localparam int MAX_DIM    = 32;
  localparam int VALUE_BITS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int IDX_W      = 5;
  localparam int DIM_W      = 6;
  localparam int CRD_W      = 17;
  localparam int ACC_W      = 32;
  localparam int WGT_W      = 17;

  typedef struct packed {
    logic                  op;
    logic [IDX_W-1:0]      voxel_x;
    logic [IDX_W-1:0]      voxel_y;
    logic [IDX_W-1:0]      voxel_z;
    logic [15:0]           voxel_value;
    logic [CRD_W-1:0]      coord_x;
    logic [CRD_W-1:0]      coord_y;
    logic [CRD_W-1:0]      coord_z;
  } in_word_t;

  typedef struct packed {
    logic [15:0] sample;
    logic        saturated;
  } out_word_t;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;
endpackage

FILE: rtl/tvs_mac.sv
`timescale 1ns / 1ps
// shared multiply, floor-shift and add
module tvs_mac (
  input  logic                               clk,
  input  logic                               load,
  input  logic                               first,
  input  logic signed [tvs_pkg::ACC_W-1:0]   opnd,
  input  logic signed [tvs_pkg::ACC_W-1:0]   addend,
  input  logic        [tvs_pkg::WGT_W-1:0]   wgt,
  output logic signed [tvs_pkg::ACC_W-1:0]   sum
);
  localparam int PW = tvs_pkg::ACC_W + tvs_pkg::WGT_W + 1;

  logic signed [PW-1:0]              prod_r;
  logic signed [tvs_pkg::ACC_W-1:0]  shifted;
  logic signed [tvs_pkg::ACC_W-1:0]  mul_in;
  logic signed [tvs_pkg::WGT_W:0]    wgt_s;

  assign shifted = prod_r[tvs_pkg::FRAC_BITS +: tvs_pkg::ACC_W];
  assign sum     = shifted + addend;
  assign mul_in  = first ? opnd : sum;
  assign wgt_s   = {1'b0, wgt};

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= mul_in * wgt_s;
    end
  end
endmodule

FILE: rtl/tricubic_volume_sampler.sv
`timescale 1ns / 1ps
// Tricubic sampler over a 32x32x32 store of 16-bit voxels. A write word stores
// one voxel. A sample word runs an axis setup state, then for each of the 16
// x-rows four memory reads plus a wait and the four cubic states C1 to C4 on
// the shared multiply unit, with a cubic pass along y after each four x-rows
// and a final pass along z, five more passes on the same unit. The input is
// stalled while a sample is in progress; the result sits in an output register.
`include "assert_macros.svh"
module tricubic_volume_sampler (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  tvs_pkg::in_word_t      in_word,
  output logic                   out_valid,
  input  logic                   out_stall,
  output tvs_pkg::out_word_t     out_word,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [3:0]             cfg_paddr,
  input  logic [31:0]            cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);
  localparam int IW = tvs_pkg::IDX_W;
  localparam int DW = tvs_pkg::DIM_W;
  localparam int CW = tvs_pkg::CRD_W;
  localparam int AW = tvs_pkg::ACC_W;
  localparam int WW = tvs_pkg::WGT_W;
  localparam int DEPTH = tvs_pkg::MAX_DIM * tvs_pkg::MAX_DIM * tvs_pkg::MAX_DIM;
  localparam int VMAX = (1 << tvs_pkg::VALUE_BITS) - 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_LAST  = 3'd3;
  localparam logic [2:0] S_C1    = 3'd4;
  localparam logic [2:0] S_C2    = 3'd5;
  localparam logic [2:0] S_C3    = 3'd6;
  localparam logic [2:0] S_C4    = 3'd7;

  localparam logic [1:0] REG_DX = 2'd0;
  localparam logic [1:0] REG_DY = 2'd1;
  localparam logic [1:0] REG_DZ = 2'd2;

  localparam logic [1:0] LV_X = 2'd0;
  localparam logic [1:0] LV_Y = 2'd1;
  localparam logic [1:0] LV_Z = 2'd2;

  logic [DW-1:0] dim_r [3];
  logic [2:0]    state_r, state_nxt;
  logic [1:0]    lvl_r, a_r, b_r, i_r;
  logic [CW-1:0] crd_r [3];
  logic [IW-1:0] idx_r [3][4];
  logic [WW-1:0] w_r [3];
  logic [IW-1:0] idx_c [3][4];
  logic [WW-1:0] w_c [3];
  logic signed [AW-1:0] v_r [4];
  logic signed [AW-1:0] yv_r [4];
  logic signed [AW-1:0] zv_r [4];
  logic signed [AW-1:0] q_r, r_r;
  logic          rd_pend_r;
  logic [1:0]    rd_slot_r;
  logic [15:0]   mem [DEPTH];
  logic [15:0]   rd_q;
  logic [3*IW-1:0] raddr;
  logic          in_fire, mem_we, cfg_wr;
  logic          out_valid_r;
  tvs_pkg::out_word_t out_word_r;
  logic signed [AW-1:0] p_c, q_c, r_c, addend_c, res_c;
  logic          mac_load, out_load;

  assign in_stall   = (state_r != S_IDLE);
  assign in_fire    = in_valid && !in_stall;
  assign out_valid  = out_valid_r;
  assign out_word   = out_word_r;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    cfg_prdata = '0;
    case (cfg_paddr[3:2])
      REG_DX:  cfg_prdata = {26'd0, dim_r[0]};
      REG_DY:  cfg_prdata = {26'd0, dim_r[1]};
      REG_DZ:  cfg_prdata = {26'd0, dim_r[2]};
      default: cfg_prdata = '0;
    endcase
  end

  assign mem_we = in_fire && (in_word.op == tvs_pkg::OP_WRITE)
                  && ({1'b0, in_word.voxel_x} < DW'(tvs_pkg::MAX_DIM))
                  && ({1'b0, in_word.voxel_y} < DW'(tvs_pkg::MAX_DIM))
                  && ({1'b0, in_word.voxel_z} < DW'(tvs_pkg::MAX_DIM));
  assign raddr = {idx_r[2][a_r], idx_r[1][b_r], idx_r[0][i_r]};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[{in_word.voxel_z, in_word.voxel_y, in_word.voxel_x}] <= in_word.voxel_value;
    end
    rd_q <= mem[raddr];
  end

  // per-axis cell index, clamped neighbours and fraction
  always_comb begin
    logic [DW-1:0]    de;
    logic [IW-1:0]    dm1, k;
    logic [CW+IW-1:0] sc;
    for (int g = 0; g < 3; g++) begin
      if (dim_r[g] == '0) begin
        de = DW'(1);
      end else if (dim_r[g] > DW'(tvs_pkg::MAX_DIM)) begin
        de = DW'(tvs_pkg::MAX_DIM);
      end else begin
        de = dim_r[g];
      end
      dm1 = IW'(de - DW'(1));
      sc  = crd_r[g] * dm1;
      if (sc[CW+IW-1:tvs_pkg::FRAC_BITS] > {1'b0, dm1}) begin
        k      = dm1;
        w_c[g] = WW'(1) << tvs_pkg::FRAC_BITS;
      end else begin
        k      = sc[tvs_pkg::FRAC_BITS +: IW];
        w_c[g] = {1'b0, sc[tvs_pkg::FRAC_BITS-1:0]};
      end
      idx_c[g][1] = k;
      idx_c[g][0] = (k != '0) ? k - IW'(1) : k;
      idx_c[g][2] = (({1'b0, k} + DW'(1)) < de) ? k + IW'(1) : k;
      idx_c[g][3] = (({1'b0, k} + DW'(2)) < de) ? k + IW'(2) : idx_c[g][2];
    end
  end

  assign p_c = v_r[3] - v_r[2] + v_r[1] - v_r[0];
  assign q_c = v_r[0] - v_r[1] - p_c;
  assign r_c = v_r[2] - v_r[0];

  always_comb begin
    case (state_r)
      S_C2:    addend_c = q_r;
      S_C3:    addend_c = r_r;
      default: addend_c = v_r[1];
    endcase
  end

  assign mac_load = (state_r == S_C1) || (state_r == S_C2) || (state_r == S_C3);

  tvs_mac u_mac (
    .clk    (clk),
    .load   (mac_load),
    .first  (state_r == S_C1),
    .opnd   (p_c),
    .addend (addend_c),
    .wgt    (w_r[lvl_r]),
    .sum    (res_c)
  );

  assign out_load = (state_r == S_C4) && (lvl_r == LV_Z) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_fire && in_word.op == tvs_pkg::OP_SAMPLE) state_nxt = S_SETUP;
      S_SETUP: state_nxt = S_READ;
      S_READ:  if (i_r == 2'd3) state_nxt = S_LAST;
      S_LAST:  state_nxt = S_C1;
      S_C1:    state_nxt = S_C2;
      S_C2:    state_nxt = S_C3;
      S_C3:    state_nxt = S_C4;
      S_C4: begin
        case (lvl_r)
          LV_X:    state_nxt = (b_r == 2'd3) ? S_C1 : S_READ;
          LV_Y:    state_nxt = (a_r == 2'd3) ? S_C1 : S_READ;
          default: if (out_load) state_nxt = S_IDLE;
        endcase
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dim_r[0]    <= DW'(32);
      dim_r[1]    <= DW'(32);
      dim_r[2]    <= DW'(32);
      out_valid_r <= 1'b0;
      rd_pend_r   <= 1'b0;
      lvl_r       <= LV_X;
      a_r         <= '0;
      b_r         <= '0;
      i_r         <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        case (cfg_paddr[3:2])
          REG_DX:  dim_r[0] <= cfg_pwdata[DW-1:0];
          REG_DY:  dim_r[1] <= cfg_pwdata[DW-1:0];
          REG_DZ:  dim_r[2] <= cfg_pwdata[DW-1:0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_stall == 1'b0) begin
        out_valid_r <= 1'b0;
      end
      rd_pend_r <= (state_r == S_READ);
      case (state_r)
        S_SETUP: begin
          lvl_r <= LV_X;
          a_r   <= '0;
          b_r   <= '0;
          i_r   <= '0;
        end
        S_READ:  i_r <= i_r + 2'd1;
        S_C4: begin
          if (lvl_r == LV_X) begin
            if (b_r == 2'd3) begin
              lvl_r <= LV_Y;
            end else begin
              b_r <= b_r + 2'd1;
            end
          end else if (lvl_r == LV_Y) begin
            b_r <= '0;
            if (a_r == 2'd3) begin
              lvl_r <= LV_Z;
            end else begin
              a_r   <= a_r + 2'd1;
              lvl_r <= LV_X;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_slot_r <= i_r;
    if (in_fire) begin
      crd_r[0] <= in_word.coord_x;
      crd_r[1] <= in_word.coord_y;
      crd_r[2] <= in_word.coord_z;
    end
    if (state_r == S_SETUP) begin
      idx_r <= idx_c;
      w_r   <= w_c;
    end
    // q and r held for the C2 and C3 adds, off the multiply path
    if (state_r == S_C1) begin
      q_r <= q_c;
      r_r <= r_c;
    end
    if (rd_pend_r) begin
      v_r[rd_slot_r] <= {{(AW-16){1'b0}}, rd_q};
    end
    if (state_r == S_C4) begin
      if (lvl_r == LV_X) begin
        yv_r[b_r] <= res_c;
        if (b_r == 2'd3) begin
          v_r[0] <= yv_r[0];
          v_r[1] <= yv_r[1];
          v_r[2] <= yv_r[2];
          v_r[3] <= res_c;
        end
      end else if (lvl_r == LV_Y) begin
        zv_r[a_r] <= res_c;
        if (a_r == 2'd3) begin
          v_r[0] <= zv_r[0];
          v_r[1] <= zv_r[1];
          v_r[2] <= zv_r[2];
          v_r[3] <= res_c;
        end
      end
    end
    if (out_load) begin
      if (res_c < 0) begin
        out_word_r.sample    <= '0;
        out_word_r.saturated <= 1'b1;
      end else if (res_c > AW'(VMAX)) begin
        out_word_r.sample    <= 16'(VMAX);
        out_word_r.saturated <= 1'b1;
      end else begin
        out_word_r.sample    <= res_c[15:0];
        out_word_r.saturated <= 1'b0;
      end
    end
  end

  `ASSERT_NEVER(a_lvl_range, clk, rst_n, lvl_r == 2'd3)
  `ASSERT_NEXT(a_query_stalls, clk, rst_n, in_fire && in_word.op == tvs_pkg::OP_SAMPLE, in_stall)
  `ASSERT_NEXT(a_out_held, clk, rst_n, out_valid_r && out_stall, out_valid_r && $stable(out_word_r))
  `ASSERT_IMPLIES(a_load_cubic, clk, rst_n, out_load, state_r == S_C4 && lvl_r == LV_Z)
endmodule
